[design/tplod_pkg.sv]
package tplod_pkg;

  localparam int LOD_W   = 2;   // width of the level field
  localparam int MASK_W  = 4;   // width of the neighbor mask
  localparam int ROW_W   = 10;  // width of the patch origin fields
  localparam int COORD_W = 11;  // grid coordinate inside or beside a patch
  localparam int STR_W   = 11;  // grid stride register
  localparam int IDX_W   = 22;  // unwrapped vertex index
  localparam int OUT_W   = 21;  // emitted vertex index

  localparam logic [STR_W-1:0] STRIDE_RESET = STR_W'(257);

  // Neighbor mask bits
  localparam int EDGE_UP    = 0;
  localparam int EDGE_RIGHT = 1;
  localparam int EDGE_DOWN  = 2;
  localparam int EDGE_LEFT  = 3;

  // How a triangle is cut before it is emitted
  typedef enum logic [1:0] {
    SPLIT_NONE,    // one plain triangle
    SPLIT_SIDE,    // midpoint on edge a-b, two triangles
    SPLIT_TB,      // midpoint on edge b-c, two triangles
    SPLIT_CORNER   // midpoints on both edges, three triangles
  } split_t;

  typedef enum logic {
    F_IDLE,
    F_WALK
  } front_state_t;

  // One triangle of one cell, as queued between front and back
  typedef struct packed {
    logic [COORD_W-1:0] row_lo;
    logic [COORD_W-1:0] row_hi;
    logic [COORD_W-1:0] col_lo;
    logic [COORD_W-1:0] col_hi;
    logic               lower;   // 0: upper-left triangle, 1: lower-right
    split_t             split;
    logic               last;    // final triangle slot of the patch
  } tri_desc_t;

endpackage

[design/terrain_patch_lod_index_generator.sv]
// Terrain patch index generator with crack stitching.
// Command channel: drive start with start_row, start_col, lod_level and
// lod_type; the patch is taken at a clock edge where start is high and busy
// is low. busy stays high until the last triangle of the patch has appeared.
// Results: each triangle shows on vertex_a/b/c for one cycle with tri_valid
// high; the final one of a patch also has last_triangle high. The receiver
// takes every result as it comes and cannot hold them off.
// Stride: grid_stride is written through cfg_valid/cfg_ready while busy is
// low; reset loads 257.
// Path: the first triangle of a patch passes the queue, then stages A, B,
// C and D and the output register, before it shows on the outputs.
// Throughput: one triangle per cycle (level 0: 32 triangles). The front
// walks one triangle slot per cycle into a 4-entry queue while the queue
// is not full; the back turns each slot into one to three triangles, one
// triangle per cycle from its emit stage.
// Reset clears the queue, the pipeline and busy; nothing is in flight after.
module terrain_patch_lod_index_generator
  import tplod_pkg::*;
#(
  parameter int PATCH_CELLS = 4,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [ROW_W-1:0]  start_row,
  input  logic [ROW_W-1:0]  start_col,
  input  logic [LOD_W-1:0]  lod_level,
  input  logic [MASK_W-1:0] lod_type,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [STR_W-1:0]  grid_stride,
  output logic              tri_valid,
  output logic [OUT_W-1:0]  vertex_a,
  output logic [OUT_W-1:0]  vertex_b,
  output logic [OUT_W-1:0]  vertex_c,
  output logic              last_triangle
);

  logic             busy_next;
  logic [STR_W-1:0] stride;
  logic             accept;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  tri_desc_t        q_wdata;
  tri_desc_t        q_rdata;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  always_comb begin
    busy_next = busy;
    if (accept) busy_next = 1'b1;
    else if (tri_valid && last_triangle) busy_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      stride <= STRIDE_RESET;
    end else begin
      busy <= busy_next;
      if (cfg_valid && cfg_ready) stride <= grid_stride;
    end
  end

  tplod_front #(
    .PATCH_CELLS(PATCH_CELLS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .start_row(start_row),
    .start_col(start_col),
    .lod_level(lod_level),
    .lod_type (lod_type),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  tplod_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty)
  );

  tplod_back u_back (
    .clk          (clk),
    .rst          (rst),
    .stride       (stride),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .tri_valid    (tri_valid),
    .vertex_a     (vertex_a),
    .vertex_b     (vertex_b),
    .vertex_c     (vertex_c),
    .last_triangle(last_triangle)
  );

endmodule

[design/tplod_fifo.sv]
module tplod_fifo
  import tplod_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tri_desc_t push_data,
  output logic      full,
  input  logic      pop,
  output tri_desc_t pop_data,
  output logic      empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  tri_desc_t         slots [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == CntW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/tplod_front.sv]
module tplod_front
  import tplod_pkg::*;
#(
  parameter int PATCH_CELLS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [ROW_W-1:0]  start_row,
  input  logic [ROW_W-1:0]  start_col,
  input  logic [LOD_W-1:0]  lod_level,
  input  logic [MASK_W-1:0] lod_type,
  input  logic              q_full,
  output logic              q_push,
  output tri_desc_t         q_data
);

  localparam int CntW   = (PATCH_CELLS > 1) ? $clog2(PATCH_CELLS) : 1;
  localparam int LvlMax = (PATCH_CELLS >= 8) ? 3 :
                          (PATCH_CELLS >= 4) ? 2 :
                          (PATCH_CELLS >= 2) ? 1 : 0;

  front_state_t       state;
  front_state_t       state_next;
  logic [ROW_W-1:0]   row0;
  logic [ROW_W-1:0]   col0;
  logic [LOD_W-1:0]   lvl;
  logic [MASK_W-1:0]  mask;
  logic [CntW-1:0]    cx;
  logic [CntW-1:0]    cy;
  logic               lower;

  logic [LOD_W-1:0]   lvl_in;
  logic [CntW-1:0]    n_last;
  logic               x_first;
  logic               y_first;
  logic               x_end;
  logic               y_end;
  logic               slot_last;
  logic [COORD_W-1:0] step;
  split_t             split;

  // Clamp the level so that at least one cell is walked
  assign lvl_in = (lod_level > LOD_W'(LvlMax)) ? LOD_W'(LvlMax) : lod_level;

  assign n_last    = CntW'((PATCH_CELLS >> lvl) - 1);
  assign step      = COORD_W'(1) << lvl;
  assign x_first   = (cx == '0);
  assign y_first   = (cy == '0);
  assign x_end     = (cx == n_last);
  assign y_end     = (cy == n_last);
  assign slot_last = lower && x_end && y_end;

  always_comb begin
    split = SPLIT_NONE;
    if (!lower) begin
      priority if (x_first && y_first) begin
        if (mask[EDGE_LEFT] && mask[EDGE_UP]) split = SPLIT_CORNER;
        else if (mask[EDGE_LEFT])             split = SPLIT_SIDE;
        else if (mask[EDGE_UP])               split = SPLIT_TB;
      end else if (x_first && mask[EDGE_LEFT]) begin
        split = SPLIT_SIDE;
      end else if (y_first && mask[EDGE_UP]) begin
        split = SPLIT_TB;
      end else begin
        split = SPLIT_NONE;
      end
    end else begin
      priority if (x_end && y_end) begin
        if (mask[EDGE_RIGHT] && mask[EDGE_DOWN]) split = SPLIT_CORNER;
        else if (mask[EDGE_RIGHT])               split = SPLIT_SIDE;
        else if (mask[EDGE_DOWN])                split = SPLIT_TB;
      end else if (x_end && mask[EDGE_RIGHT]) begin
        split = SPLIT_SIDE;
      end else if (y_end && mask[EDGE_DOWN]) begin
        split = SPLIT_TB;
      end else begin
        split = SPLIT_NONE;
      end
    end
  end

  always_comb begin
    q_data.row_lo = COORD_W'(row0) + (COORD_W'(cy) << lvl);
    q_data.col_lo = COORD_W'(col0) + (COORD_W'(cx) << lvl);
    q_data.row_hi = q_data.row_lo + step;
    q_data.col_hi = q_data.col_lo + step;
    q_data.lower  = lower;
    q_data.split  = split;
    q_data.last   = slot_last;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (accept) state_next = F_WALK;
      F_WALK: if (q_push && slot_last) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      F_WALK:  q_push = !q_full;
      default: q_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx    <= '0;
      cy    <= '0;
      lower <= 1'b0;
    end else if (accept && state == F_IDLE) begin
      cx    <= '0;
      cy    <= '0;
      lower <= 1'b0;
    end else if (q_push) begin
      lower <= !lower;
      if (lower) begin
        if (x_end) begin
          cx <= '0;
          cy <= cy + 1'b1;
        end else begin
          cx <= cx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && state == F_IDLE) begin
      row0 <= start_row;
      col0 <= start_col;
      lvl  <= lvl_in;
      // a one-vertex edge has no midpoint: drop the mask at level zero
      mask <= (lvl_in == '0) ? '0 : lod_type;
    end
  end

endmodule

[design/tplod_back.sv]
module tplod_back
  import tplod_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [STR_W-1:0] stride,
  input  logic             q_empty,
  input  tri_desc_t        q_data,
  output logic             q_pop,
  output logic             tri_valid,
  output logic [OUT_W-1:0] vertex_a,
  output logic [OUT_W-1:0] vertex_b,
  output logic [OUT_W-1:0] vertex_c,
  output logic             last_triangle
);

  // Stage A: descriptor
  logic               a_valid;
  tri_desc_t          a_desc;
  // Stage B: row products
  logic               b_valid;
  logic [IDX_W-1:0]   b_prod_lo;
  logic [IDX_W-1:0]   b_prod_hi;
  logic [COORD_W-1:0] b_col_lo;
  logic [COORD_W-1:0] b_col_hi;
  logic               b_lower;
  split_t             b_split;
  logic               b_last;
  // Stage C: corner indices
  logic               c_valid;
  logic [IDX_W-1:0]   c_va;
  logic [IDX_W-1:0]   c_vb;
  logic [IDX_W-1:0]   c_vc;
  split_t             c_split;
  logic               c_last;
  // Stage D: midpoints and emission
  logic               d_valid;
  logic [IDX_W-1:0]   d_va;
  logic [IDX_W-1:0]   d_vb;
  logic [IDX_W-1:0]   d_vc;
  logic [IDX_W-1:0]   d_mab;
  logic [IDX_W-1:0]   d_mbc;
  split_t             d_split;
  logic               d_last;
  logic [1:0]         d_sub;

  logic               a_ready;
  logic               b_ready;
  logic               c_ready;
  logic               d_ready;
  logic               d_done;
  logic [1:0]         sub_last;
  logic [IDX_W-1:0]   lo_a;
  logic [IDX_W-1:0]   lo_b;
  logic [IDX_W-1:0]   lo_c;
  logic [IDX_W:0]     sum_ab;
  logic [IDX_W:0]     sum_bc;
  logic [IDX_W-1:0]   e_a;
  logic [IDX_W-1:0]   e_b;
  logic [IDX_W-1:0]   e_c;

  always_comb begin
    unique case (d_split)
      SPLIT_NONE:   sub_last = 2'd0;
      SPLIT_CORNER: sub_last = 2'd2;
      default:      sub_last = 2'd1;
    endcase
  end

  assign d_done  = d_valid && (d_sub == sub_last);
  assign d_ready = !d_valid || d_done;
  assign c_ready = !c_valid || d_ready;
  assign b_ready = !b_valid || c_ready;
  assign a_ready = !a_valid || b_ready;
  assign q_pop   = !q_empty && a_ready;

  // Upper-left: (row_hi,col_lo) (row_lo,col_lo) (row_lo,col_hi)
  // Lower-right: (row_lo,col_hi) (row_hi,col_hi) (row_hi,col_lo)
  always_comb begin
    if (b_lower) begin
      lo_a = b_prod_lo + IDX_W'(b_col_hi);
      lo_b = b_prod_hi + IDX_W'(b_col_hi);
      lo_c = b_prod_hi + IDX_W'(b_col_lo);
    end else begin
      lo_a = b_prod_hi + IDX_W'(b_col_lo);
      lo_b = b_prod_lo + IDX_W'(b_col_lo);
      lo_c = b_prod_lo + IDX_W'(b_col_hi);
    end
  end

  assign sum_ab = {1'b0, c_va} + {1'b0, c_vb};
  assign sum_bc = {1'b0, c_vb} + {1'b0, c_vc};

  always_comb begin
    e_a = d_va;
    e_b = d_vb;
    e_c = d_vc;
    unique case (d_split)
      SPLIT_NONE: begin
        e_a = d_va;  e_b = d_vb;  e_c = d_vc;
      end
      SPLIT_SIDE: begin
        if (d_sub == 2'd0) begin
          e_a = d_vc;  e_b = d_va;   e_c = d_mab;
        end else begin
          e_a = d_vc;  e_b = d_mab;  e_c = d_vb;
        end
      end
      SPLIT_TB: begin
        if (d_sub == 2'd0) begin
          e_a = d_va;  e_b = d_vb;   e_c = d_mbc;
        end else begin
          e_a = d_va;  e_b = d_mbc;  e_c = d_vc;
        end
      end
      SPLIT_CORNER: begin
        if (d_sub == 2'd0) begin
          e_a = d_mab; e_b = d_vb;   e_c = d_mbc;
        end else if (d_sub == 2'd1) begin
          e_a = d_mab; e_b = d_mbc;  e_c = d_va;
        end else begin
          e_a = d_va;  e_b = d_mbc;  e_c = d_vc;
        end
      end
      default: begin
        e_a = d_va;  e_b = d_vb;  e_c = d_vc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      d_sub     <= 2'd0;
      tri_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= q_pop;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
      if (d_ready) begin
        d_valid <= c_valid;
        d_sub   <= 2'd0;
      end else begin
        d_sub <= d_sub + 1'b1;
      end
      tri_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_desc <= q_data;
    end
    if (b_ready) begin
      b_prod_lo <= IDX_W'(a_desc.row_lo) * IDX_W'(stride);
      b_prod_hi <= IDX_W'(a_desc.row_hi) * IDX_W'(stride);
      b_col_lo  <= a_desc.col_lo;
      b_col_hi  <= a_desc.col_hi;
      b_lower   <= a_desc.lower;
      b_split   <= a_desc.split;
      b_last    <= a_desc.last;
    end
    if (c_ready) begin
      c_va    <= lo_a;
      c_vb    <= lo_b;
      c_vc    <= lo_c;
      c_split <= b_split;
      c_last  <= b_last;
    end
    if (d_ready) begin
      d_va    <= c_va;
      d_vb    <= c_vb;
      d_vc    <= c_vc;
      d_mab   <= sum_ab[IDX_W:1];
      d_mbc   <= sum_bc[IDX_W:1];
      d_split <= c_split;
      d_last  <= c_last;
    end
    // wrap indices to the output width
    vertex_a      <= e_a[OUT_W-1:0];
    vertex_b      <= e_b[OUT_W-1:0];
    vertex_c      <= e_c[OUT_W-1:0];
    last_triangle <= d_done && d_last;
  end

endmodule

[tb/tb_top.sv]
module tb_top
  import tplod_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PATCH_CELLS = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASE_ITEMS = 55;

  // Neighbor mask codes
  localparam logic [MASK_W-1:0] MASK_NONE  = '0;
  localparam logic [MASK_W-1:0] MASK_UP    = MASK_W'(1 << EDGE_UP);
  localparam logic [MASK_W-1:0] MASK_RIGHT = MASK_W'(1 << EDGE_RIGHT);
  localparam logic [MASK_W-1:0] MASK_DOWN  = MASK_W'(1 << EDGE_DOWN);
  localparam logic [MASK_W-1:0] MASK_LEFT  = MASK_W'(1 << EDGE_LEFT);
  localparam logic [MASK_W-1:0] MASK_ALL   = '1;

  localparam logic [LOD_W-1:0] LOD_FINE   = LOD_W'(0);
  localparam logic [LOD_W-1:0] LOD_MID    = LOD_W'(1);
  localparam logic [LOD_W-1:0] LOD_COARSE = LOD_W'(2);
  localparam logic [LOD_W-1:0] LOD_OVER   = LOD_W'(3);

  localparam logic [ROW_W-1:0] ORIGIN_MAX = '1;
  localparam logic [STR_W-1:0] STRIDE_MAX = '1;

  typedef struct {
    logic [OUT_W-1:0] va;
    logic [OUT_W-1:0] vb;
    logic [OUT_W-1:0] vc;
    logic             last_tri;
  } tri_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [ROW_W-1:0]  start_row = '0;
  logic [ROW_W-1:0]  start_col = '0;
  logic [LOD_W-1:0]  lod_level = '0;
  logic [MASK_W-1:0] lod_type = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [STR_W-1:0]  grid_stride = STRIDE_RESET;
  logic              tri_valid;
  logic [OUT_W-1:0]  vertex_a;
  logic [OUT_W-1:0]  vertex_b;
  logic [OUT_W-1:0]  vertex_c;
  logic              last_triangle;

  tri_t             expected_tris[$];
  logic [STR_W-1:0] stride_model = STRIDE_RESET;
  int               errors = 0;
  int               cycles = 0;
  bit               no_gaps = 1'b0;

  terrain_patch_lod_index_generator DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .start_row    (start_row),
    .start_col    (start_col),
    .lod_level    (lod_level),
    .lod_type     (lod_type),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .grid_stride  (grid_stride),
    .tri_valid    (tri_valid),
    .vertex_a     (vertex_a),
    .vertex_b     (vertex_b),
    .vertex_c     (vertex_c),
    .last_triangle(last_triangle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void push_tri(longint unsigned a, longint unsigned b,
                                   longint unsigned c);
    tri_t entry;
    entry = '{OUT_W'(a), OUT_W'(b), OUT_W'(c), 1'b0};
    expected_tris.insert(expected_tris.size(), entry);
  endfunction

  function automatic split_t cut_for(logic side, logic tb);
    if (side && tb) return SPLIT_CORNER;
    if (side) return SPLIT_SIDE;
    if (tb) return SPLIT_TB;
    return SPLIT_NONE;
  endfunction

  // Edge a-b is the side edge, edge b-c the top or bottom edge
  function automatic void emit_cut(longint unsigned a, longint unsigned b,
                                   longint unsigned c, split_t cut);
    longint unsigned m;
    longint unsigned t;
    case (cut)
      SPLIT_SIDE: begin
        m = (a + b) >> 1;
        push_tri(c, a, m);
        push_tri(c, m, b);
      end
      SPLIT_TB: begin
        m = (b + c) >> 1;
        push_tri(a, b, m);
        push_tri(a, m, c);
      end
      SPLIT_CORNER: begin
        t = (b + c) >> 1;
        m = (a + b) >> 1;
        push_tri(m, b, t);
        push_tri(m, t, a);
        push_tri(a, t, c);
      end
      default: push_tri(a, b, c);
    endcase
  endfunction

  function automatic void predict_patch(logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                                        logic [LOD_W-1:0] lvl_in,
                                        logic [MASK_W-1:0] mask_in);
    int lvl;
    int n;
    int step;
    logic [MASK_W-1:0] mask;
    longint unsigned r, c, rn, cn, st;
    split_t up_cut, low_cut;
    lvl = int'(lvl_in);
    mask = mask_in;
    while (lvl > 0 && (PATCH_CELLS >> lvl) == 0) lvl--;
    // a one-vertex edge has no midpoint: drop the mask
    if (lvl == 0) mask = MASK_NONE;
    n = PATCH_CELLS >> lvl;
    step = 1 << lvl;
    st = 64'(stride_model);
    for (int y = 0; y < n; y++) begin
      for (int x = 0; x < n; x++) begin
        r = 64'(row) + 64'(y * step);
        c = 64'(col) + 64'(x * step);
        rn = r + 64'(step);
        cn = c + 64'(step);
        if (x == 0 && y == 0) up_cut = cut_for(mask[EDGE_LEFT], mask[EDGE_UP]);
        else if (x == 0) up_cut = cut_for(mask[EDGE_LEFT], 1'b0);
        else if (y == 0) up_cut = cut_for(1'b0, mask[EDGE_UP]);
        else up_cut = SPLIT_NONE;
        emit_cut(rn * st + c, r * st + c, r * st + cn, up_cut);
        if (x == n - 1 && y == n - 1) low_cut = cut_for(mask[EDGE_RIGHT], mask[EDGE_DOWN]);
        else if (x == n - 1) low_cut = cut_for(mask[EDGE_RIGHT], 1'b0);
        else if (y == n - 1) low_cut = cut_for(1'b0, mask[EDGE_DOWN]);
        else low_cut = SPLIT_NONE;
        emit_cut(r * st + cn, rn * st + cn, rn * st + c, low_cut);
      end
    end
    expected_tris[expected_tris.size() - 1].last_tri = 1'b1;
  endfunction

  // Leave start high after the transfer; the next call or end_patches settles it
  task automatic send_patch(logic [ROW_W-1:0] row, logic [ROW_W-1:0] col,
                            logic [LOD_W-1:0] lvl, logic [MASK_W-1:0] mask);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    start_row <= row;
    start_col <= col;
    lod_level <= lvl;
    lod_type <= mask;
    do @(posedge clk); while (busy);
    predict_patch(row, col, lvl, mask);
  endtask

  task automatic end_patches();
    start <= 1'b0;
    do @(posedge clk); while (expected_tris.size() != 0 || busy);
  endtask

  task automatic write_stride(logic [STR_W-1:0] value);
    cfg_valid <= 1'b1;
    grid_stride <= value;
    do @(posedge clk); while (!cfg_ready);
    stride_model = value;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    tri_t want;
    if (!rst && tri_valid) begin
      if (expected_tris.size() == 0) begin
        $error("unexpected triangle a=%0d b=%0d c=%0d", vertex_a, vertex_b, vertex_c);
        errors++;
      end else begin
        want = expected_tris.pop_front();
        if (vertex_a !== want.va) begin
          $error("vertex_a expected %0d actual %0d", want.va, vertex_a);
          errors++;
        end
        if (vertex_b !== want.vb) begin
          $error("vertex_b expected %0d actual %0d", want.vb, vertex_b);
          errors++;
        end
        if (vertex_c !== want.vc) begin
          $error("vertex_c expected %0d actual %0d", want.vc, vertex_c);
          errors++;
        end
        if (last_triangle !== want.last_tri) begin
          $error("last_triangle expected %0b actual %0b", want.last_tri, last_triangle);
          errors++;
        end
      end
    end
  end

  // Reset stride, every split shape, level clamp and origin extremes
  task automatic test_split_shapes();
    send_patch('0, '0, LOD_FINE, MASK_NONE);
    send_patch(ORIGIN_MAX, ORIGIN_MAX, LOD_FINE, MASK_ALL);
    send_patch(10'd5, 10'd9, LOD_MID, MASK_NONE);
    send_patch(10'd5, 10'd9, LOD_MID, MASK_UP);
    send_patch(10'd100, 10'd3, LOD_MID, MASK_RIGHT);
    send_patch(10'd7, 10'd200, LOD_MID, MASK_DOWN);
    send_patch(10'd0, 10'd1, LOD_MID, MASK_LEFT);
    send_patch(10'd33, 10'd44, LOD_MID, MASK_UP | MASK_LEFT);
    send_patch(10'd512, 10'd511, LOD_MID, MASK_RIGHT | MASK_DOWN);
    send_patch(ORIGIN_MAX, '0, LOD_MID, MASK_ALL);
    send_patch('0, ORIGIN_MAX, LOD_COARSE, MASK_UP | MASK_LEFT);
    send_patch(10'd64, 10'd64, LOD_COARSE, MASK_RIGHT | MASK_DOWN);
    send_patch(10'd1, 10'd2, LOD_COARSE, MASK_ALL);
    send_patch(10'd300, 10'd301, LOD_OVER, MASK_UP | MASK_DOWN);
    send_patch(ORIGIN_MAX, ORIGIN_MAX, LOD_OVER, MASK_RIGHT | MASK_LEFT);
    end_patches();
  endtask

  // Stride extremes, including values below the usable range and index wrap
  task automatic test_stride_extremes();
    logic [STR_W-1:0] strides[5] = '{STR_W'(2), STR_W'(1025), STR_W'(0), STR_W'(1),
                                     STRIDE_MAX};
    foreach (strides[i]) begin
      write_stride(strides[i]);
      send_patch(ORIGIN_MAX, ORIGIN_MAX, LOD_MID, MASK_ALL);
      send_patch(ORIGIN_MAX, '0, LOD_FINE, MASK_NONE);
      end_patches();
    end
  endtask

  task automatic test_random_patches();
    logic [STR_W-1:0] strides[6] = '{STR_W'(2), STR_W'(1025), STRIDE_MAX, STR_W'(0),
                                     STR_W'(1), STR_W'(257)};
    foreach (strides[p]) begin
      if (p == 5) write_stride(STR_W'($urandom_range(2, 1025)));
      else write_stride(strides[p]);
      for (int i = 0; i < RAND_PHASE_ITEMS; i++) begin
        // back-to-back burst in the middle of each phase
        no_gaps = (i >= 35 && i < 47);
        send_patch(ROW_W'($urandom_range(0, 1023)), ROW_W'($urandom_range(0, 1023)),
                   LOD_W'($urandom_range(0, 3)), MASK_W'($urandom_range(0, 15)));
      end
      no_gaps = 1'b0;
      end_patches();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_split_shapes();
    test_stride_extremes();
    test_random_patches();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_tris.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
design/tplod_pkg.sv
design/tplod_fifo.sv
design/tplod_front.sv
design/tplod_back.sv
design/terrain_patch_lod_index_generator.sv
tb/tb_top.sv
